// File: hw/rtl/gbar_pkg.sv
`timescale 1ns / 1ps

package gbar_pkg;

   localparam int unsigned AXIS_W   = 8;
   localparam int unsigned BUTTON_W = 16;
   localparam int unsigned WORD_W   = 24;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned INDEX_W  = 4;

   localparam logic [INDEX_W-1:0] CSR_STICK_CENTER  = 4'd0;
   localparam logic [INDEX_W-1:0] CSR_DEAD_ZONE     = 4'd1;
   localparam logic [INDEX_W-1:0] CSR_REPEAT_DELAY  = 4'd2;
   localparam logic [INDEX_W-1:0] CSR_REPEAT_RELOAD = 4'd3;

   localparam logic [AXIS_W-1:0]  STICK_CENTER_RST  = 8'd128;
   localparam logic [AXIS_W-1:0]  DEAD_ZONE_RST     = 8'd64;
   localparam logic [COUNT_W-1:0] REPEAT_DELAY_RST  = 4'd10;
   localparam logic [COUNT_W-1:0] REPEAT_RELOAD_RST = 4'd6;

   typedef struct packed {
      logic below;
      logic above;
   } axis_dir_type;

endpackage

// File: hw/rtl/gbar_axis.sv
`timescale 1ns / 1ps

module gbar_axis (
   input  logic [gbar_pkg::AXIS_W-1:0] axis,
   input  logic [gbar_pkg::AXIS_W-1:0] center,
   input  logic [gbar_pkg::AXIS_W-1:0] dead_zone,
   output gbar_pkg::axis_dir_type      dir
);
   import gbar_pkg::*;

   logic [AXIS_W:0] axis_plus_dead;
   logic [AXIS_W:0] center_plus_dead;

   // axis < center - dead  <=>  axis + dead < center, no wrap at 9 bits
   assign axis_plus_dead   = {1'b0, axis} + {1'b0, dead_zone};
   assign center_plus_dead = {1'b0, center} + {1'b0, dead_zone};

   always_comb begin
      dir.below = (axis_plus_dead < {1'b0, center});
      dir.above = !dir.below && ({1'b0, axis} > center_plus_dead);
   end

endmodule

// File: hw/rtl/gamepad_button_auto_repeat.sv
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------------
// request   | in        | req_valid/req_ready  | digital_buttons, left/right x/y
// response  | out       | rsp_valid/rsp_ready  | held_word, pressed_word
// csr write | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// one request per cycle sustained while rsp_ready stays high; an accepted request passes
// the input register, then the result register, before rsp_valid rises
// the response follows from one pass of axis compares and the repeat counter update
// reset clears valids, the previous word and the same count, and loads the csr defaults
// a stalled response holds the result and the input register keeps one more request
// csr_ready is always high; unknown csr indexes are ignored

module gamepad_button_auto_repeat (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gbar_pkg::BUTTON_W-1:0]  req_digital_buttons,
   input  logic [gbar_pkg::AXIS_W-1:0]    req_left_x,
   input  logic [gbar_pkg::AXIS_W-1:0]    req_left_y,
   input  logic [gbar_pkg::AXIS_W-1:0]    req_right_x,
   input  logic [gbar_pkg::AXIS_W-1:0]    req_right_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gbar_pkg::WORD_W-1:0]    rsp_held_word,
   output logic [gbar_pkg::WORD_W-1:0]    rsp_pressed_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gbar_pkg::INDEX_W-1:0]   csr_index,
   input  logic [gbar_pkg::AXIS_W-1:0]    csr_wdata
);
   import gbar_pkg::*;

   logic [AXIS_W-1:0]   stick_center_ff, stick_center_in;
   logic [AXIS_W-1:0]   dead_zone_ff, dead_zone_in;
   logic [COUNT_W-1:0]  repeat_delay_ff, repeat_delay_in;
   logic [COUNT_W-1:0]  repeat_reload_ff, repeat_reload_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [BUTTON_W-1:0] s1_buttons_ff, s1_buttons_in;
   logic [AXIS_W-1:0]   s1_left_x_ff, s1_left_x_in;
   logic [AXIS_W-1:0]   s1_left_y_ff, s1_left_y_in;
   logic [AXIS_W-1:0]   s1_right_x_ff, s1_right_x_in;
   logic [AXIS_W-1:0]   s1_right_y_ff, s1_right_y_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   held_ff, held_in;
   logic [WORD_W-1:0]   pressed_ff, pressed_in;

   logic [WORD_W-1:0]   previous_word_ff, previous_word_in;
   logic [COUNT_W-1:0]  same_count_ff, same_count_in;

   axis_dir_type        dir_left_x, dir_left_y, dir_right_x, dir_right_y;
   logic [WORD_W-1:0]   word;
   logic [COUNT_W:0]    count_next;
   logic                advance;
   logic                word_same;

   gbar_axis u_left_x (
      .axis(s1_left_x_ff), .center(stick_center_ff), .dead_zone(dead_zone_ff),
      .dir(dir_left_x)
   );
   gbar_axis u_left_y (
      .axis(s1_left_y_ff), .center(stick_center_ff), .dead_zone(dead_zone_ff),
      .dir(dir_left_y)
   );
   gbar_axis u_right_x (
      .axis(s1_right_x_ff), .center(stick_center_ff), .dead_zone(dead_zone_ff),
      .dir(dir_right_x)
   );
   gbar_axis u_right_y (
      .axis(s1_right_y_ff), .center(stick_center_ff), .dead_zone(dead_zone_ff),
      .dir(dir_right_y)
   );

   // direction bits: left up/right/down/left, then right up/right/down/left
   assign word = {dir_right_x.below, dir_right_y.above, dir_right_x.above, dir_right_y.below,
                  dir_left_x.below,  dir_left_y.above,  dir_left_x.above,  dir_left_y.below,
                  s1_buttons_ff};

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign word_same  = (word == previous_word_ff);
   assign count_next = {1'b0, same_count_ff} + {{COUNT_W{1'b0}}, 1'b1};

   always_comb begin
      stick_center_in  = stick_center_ff;
      dead_zone_in     = dead_zone_ff;
      repeat_delay_in  = repeat_delay_ff;
      repeat_reload_in = repeat_reload_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STICK_CENTER:  stick_center_in  = csr_wdata;
            CSR_DEAD_ZONE:     dead_zone_in     = csr_wdata;
            CSR_REPEAT_DELAY:  repeat_delay_in  = csr_wdata[COUNT_W-1:0];
            CSR_REPEAT_RELOAD: repeat_reload_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_buttons_in = s1_buttons_ff;
      s1_left_x_in  = s1_left_x_ff;
      s1_left_y_in  = s1_left_y_ff;
      s1_right_x_in = s1_right_x_ff;
      s1_right_y_in = s1_right_y_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_buttons_in = req_digital_buttons;
            s1_left_x_in  = req_left_x;
            s1_left_y_in  = req_left_y;
            s1_right_x_in = req_right_x;
            s1_right_y_in = req_right_y;
         end
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      held_in          = held_ff;
      pressed_in       = pressed_ff;
      previous_word_in = previous_word_ff;
      same_count_in    = same_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         pressed_in   = word & ~previous_word_ff;
         held_in      = word & ~previous_word_ff;
         if (word_same) begin
            if (count_next >= {1'b0, repeat_delay_ff}) begin
               held_in       = word;
               same_count_in = repeat_reload_ff;
            end else begin
               same_count_in = count_next[COUNT_W-1:0];
            end
         end else begin
            same_count_in    = '0;
            previous_word_in = word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_center_ff  <= STICK_CENTER_RST;
         dead_zone_ff     <= DEAD_ZONE_RST;
         repeat_delay_ff  <= REPEAT_DELAY_RST;
         repeat_reload_ff <= REPEAT_RELOAD_RST;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         previous_word_ff <= '0;
         same_count_ff    <= '0;
      end else begin
         stick_center_ff  <= stick_center_in;
         dead_zone_ff     <= dead_zone_in;
         repeat_delay_ff  <= repeat_delay_in;
         repeat_reload_ff <= repeat_reload_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         previous_word_ff <= previous_word_in;
         same_count_ff    <= same_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_buttons_ff <= s1_buttons_in;
      s1_left_x_ff  <= s1_left_x_in;
      s1_left_y_ff  <= s1_left_y_in;
      s1_right_x_ff <= s1_right_x_in;
      s1_right_y_ff <= s1_right_y_in;
      held_ff       <= held_in;
      pressed_ff    <= pressed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_held_word    = held_ff;
   assign rsp_pressed_word = pressed_ff;

   // pressed bits always appear in held
   a_pressed_in_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((pressed_ff & ~held_ff) == '0))
      else $error("pressed bit missing from held word");

   // held is either the new presses or a repeat with nothing new
   a_held_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((held_ff == pressed_ff) || (pressed_ff == '0)))
      else $error("held word neither presses nor repeat");

   // a changed word restarts the count and becomes the previous word
   a_change_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && !word_same) |=> (same_count_ff == '0) && (previous_word_ff == $past(word)))
      else $error("word change did not restart repeat count");

   // no response without a request in the input register
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff)
      else $error("response without request");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import gbar_pkg::*;

   localparam int QUIET_LIMIT   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_STALL    = 60;
   localparam int PHASES        = 14;
   localparam int PHASE_ITEMS   = 50;

   typedef struct {
      logic [BUTTON_W-1:0] buttons;
      logic [AXIS_W-1:0]   left_x;
      logic [AXIS_W-1:0]   left_y;
      logic [AXIS_W-1:0]   right_x;
      logic [AXIS_W-1:0]   right_y;
   } sample_type;

   typedef struct {
      logic [WORD_W-1:0] held;
      logic [WORD_W-1:0] pressed;
   } key_event_type;

   class repeat_scoreboard;
      logic [AXIS_W-1:0]  center;
      logic [AXIS_W-1:0]  dead_zone;
      logic [COUNT_W-1:0] delay;
      logic [COUNT_W-1:0] reload;
      logic [WORD_W-1:0]  last_word;
      logic [COUNT_W-1:0] run_count;
      key_event_type      expected_events[$];
      int                 errors;
      int                 requests;
      int                 responses;
      int                 repeats;
      int                 writes;

      function new();
         center    = STICK_CENTER_RST;
         dead_zone = DEAD_ZONE_RST;
         delay     = REPEAT_DELAY_RST;
         reload    = REPEAT_RELOAD_RST;
         last_word = '0;
         run_count = '0;
         errors    = 0;
         requests  = 0;
         responses = 0;
         repeats   = 0;
         writes    = 0;
      endfunction

      function void write_register(logic [INDEX_W-1:0] index, logic [AXIS_W-1:0] data);
         writes++;
         case (index)
            CSR_STICK_CENTER:  center = data;
            CSR_DEAD_ZONE:     dead_zone = data;
            CSR_REPEAT_DELAY:  delay = data[COUNT_W-1:0];
            CSR_REPEAT_RELOAD: reload = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function axis_dir_type classify(logic [AXIS_W-1:0] pos);
         int p, c, d;
         axis_dir_type dir;
         p = int'(pos);
         c = int'(center);
         d = int'(dead_zone);
         dir.below = 1'b0;
         dir.above = 1'b0;
         if (p < c - d) begin
            dir.below = 1'b1;
         end else if (p > c + d) begin
            dir.above = 1'b1;
         end
         return dir;
      endfunction

      function void note_request(sample_type s);
         logic [WORD_W-1:0] word;
         logic [COUNT_W:0]  step;
         axis_dir_type      dir;
         key_event_type     ev;
         requests++;
         word = {8'h00, s.buttons};
         dir = classify(s.left_y);
         word[16] = dir.below;
         word[18] = dir.above;
         dir = classify(s.left_x);
         word[19] = dir.below;
         word[17] = dir.above;
         dir = classify(s.right_y);
         word[20] = dir.below;
         word[22] = dir.above;
         dir = classify(s.right_x);
         word[23] = dir.below;
         word[21] = dir.above;
         ev.pressed = word & ~last_word;
         ev.held = ev.pressed;
         if (word == last_word) begin
            step = {1'b0, run_count} + {{COUNT_W{1'b0}}, 1'b1};
            if (step >= {1'b0, delay}) begin
               ev.held = word;
               run_count = reload;
               repeats++;
            end else begin
               run_count = step[COUNT_W-1:0];
            end
         end else begin
            run_count = '0;
            last_word = word;
         end
         expected_events.push_back(ev);
      endfunction

      function void check_response(logic [WORD_W-1:0] held, logic [WORD_W-1:0] pressed);
         key_event_type ev;
         responses++;
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected response expected none actual held %06h pressed %06h",
                     $time, held, pressed);
            return;
         end
         ev = expected_events.pop_front();
         if (held !== ev.held) begin
            errors++;
            $display("%0t: held_word mismatch expected %06h actual %06h", $time, ev.held, held);
         end
         if (pressed !== ev.pressed) begin
            errors++;
            $display("%0t: pressed_word mismatch expected %06h actual %06h",
                     $time, ev.pressed, pressed);
         end
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BUTTON_W-1:0] req_digital_buttons = '0;
   logic [AXIS_W-1:0]   req_left_x = '0;
   logic [AXIS_W-1:0]   req_left_y = '0;
   logic [AXIS_W-1:0]   req_right_x = '0;
   logic [AXIS_W-1:0]   req_right_y = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORD_W-1:0]   rsp_held_word;
   logic [WORD_W-1:0]   rsp_pressed_word;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index = '0;
   logic [AXIS_W-1:0]   csr_wdata = '0;

   repeat_scoreboard board;
   bit                  req_burst = 1'b0;
   bit                  rsp_burst = 1'b0;
   bit                  hold_rsp = 1'b0;
   int                  quiet_cycles = 0;
   int                  settings_used = 1;

   gamepad_button_auto_repeat uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_digital_buttons (req_digital_buttons),
      .req_left_x          (req_left_x),
      .req_left_y          (req_left_y),
      .req_right_x         (req_right_x),
      .req_right_y         (req_right_y),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_held_word       (rsp_held_word),
      .rsp_pressed_word    (rsp_pressed_word),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         sample_type s;
         s.buttons = req_digital_buttons;
         s.left_x  = req_left_x;
         s.left_y  = req_left_y;
         s.right_x = req_right_x;
         s.right_y = req_right_y;
         if (req_valid && req_ready) board.note_request(s);
         if (rsp_valid && rsp_ready) board.check_response(rsp_held_word, rsp_pressed_word);
         if (csr_valid && csr_ready) board.write_register(csr_index, csr_wdata);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // response side: random back-pressure, one long hold when asked
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            gap = LONG_STALL;
            hold_rsp = 1'b0;
         end else if (rsp_burst) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 10);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic sample_type make_sample(logic [BUTTON_W-1:0] b, logic [AXIS_W-1:0] lx,
                                              logic [AXIS_W-1:0] ly, logic [AXIS_W-1:0] rx,
                                              logic [AXIS_W-1:0] ry);
      sample_type s;
      s.buttons = b;
      s.left_x  = lx;
      s.left_y  = ly;
      s.right_x = rx;
      s.right_y = ry;
      return s;
   endfunction

   // biased toward the threshold edges of the current setting
   function automatic logic [AXIS_W-1:0] pick_axis();
      int c, d, v;
      c = int'(board.center);
      d = int'(board.dead_zone);
      case ($urandom_range(0, 7))
         0: v = c - d - 1;
         1: v = c - d;
         2: v = c + d;
         3: v = c + d + 1;
         4: v = c;
         default: v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[AXIS_W-1:0];
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      if ($urandom_range(0, 3) == 0)
         s.buttons = 16'd1 << $urandom_range(0, 15);
      else
         s.buttons = BUTTON_W'($urandom);
      s.left_x  = pick_axis();
      s.left_y  = pick_axis();
      s.right_x = pick_axis();
      s.right_y = pick_axis();
      return s;
   endfunction

   task automatic send_sample(input sample_type s);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_digital_buttons <= s.buttons;
      req_left_x          <= s.left_x;
      req_left_y          <= s.left_y;
      req_right_x         <= s.right_x;
      req_right_y         <= s.right_y;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings(input logic [AXIS_W-1:0] center, input logic [AXIS_W-1:0] zone,
                                   input logic [COUNT_W-1:0] delay,
                                   input logic [COUNT_W-1:0] reload);
      logic [INDEX_W-1:0] idx[5];
      logic [AXIS_W-1:0]  val[5];
      idx[0] = CSR_STICK_CENTER;
      idx[1] = CSR_DEAD_ZONE;
      idx[2] = CSR_REPEAT_DELAY;
      idx[3] = CSR_REPEAT_RELOAD;
      idx[4] = INDEX_W'($urandom_range(CSR_REPEAT_RELOAD + 1, (1 << INDEX_W) - 1));
      val[0] = center;
      val[1] = zone;
      val[2] = {4'($urandom), delay};
      val[3] = {4'($urandom), reload};
      val[4] = AXIS_W'($urandom);
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // runs of an unchanged sample reach the repeat logic, singles act as noise
   task automatic random_phase(input int count);
      int         sent, run_len;
      sample_type base;
      sent = 0;
      while (sent < count) begin
         base = random_sample();
         run_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
         for (int k = 0; k < run_len && sent < count; k++) begin
            if ($urandom_range(0, 19) == 0) base.buttons ^= 16'd1 << $urandom_range(0, 15);
            if ($urandom_range(0, 19) == 0) base.right_x = pick_axis();
            send_sample(base);
            sent++;
         end
      end
   endtask

   initial begin
      logic [AXIS_W-1:0]  center, zone;
      logic [COUNT_W-1:0] delay, reload;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: thresholds at 64 and 192, repeat after 10 then every 4
      req_burst = 1'($urandom_range(0, 1));
      send_sample(make_sample(16'h0000, 8'd128, 8'd128, 8'd128, 8'd128));
      send_sample(make_sample(16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0));
      send_sample(make_sample(16'h0000, 8'd255, 8'd255, 8'd255, 8'd255));
      send_sample(make_sample(16'h0000, 8'd63, 8'd63, 8'd63, 8'd63));
      send_sample(make_sample(16'h0000, 8'd64, 8'd64, 8'd64, 8'd64));
      send_sample(make_sample(16'h0000, 8'd192, 8'd192, 8'd192, 8'd192));
      send_sample(make_sample(16'h0000, 8'd193, 8'd193, 8'd193, 8'd193));
      send_sample(make_sample(16'h8000, 8'd0, 8'd255, 8'd255, 8'd0));
      repeat (16) send_sample(make_sample(16'h0001, 8'd128, 8'd128, 8'd128, 8'd128));
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               center = 8'd0; zone = 8'd0; delay = 4'd1; reload = 4'd0;
            end
            1: begin
               center = 8'd255; zone = 8'd255; delay = 4'd15; reload = 4'd14;
            end
            2: begin
               center = 8'd0; zone = 8'd255; delay = 4'd0; reload = 4'd15;
            end
            3: begin
               center = 8'd255; zone = 8'd0; delay = 4'd3; reload = 4'd9;
            end
            4: begin
               center = STICK_CENTER_RST; zone = DEAD_ZONE_RST;
               delay = REPEAT_DELAY_RST; reload = REPEAT_RELOAD_RST;
            end
            default: begin
               center = AXIS_W'($urandom_range(0, 255));
               zone   = AXIS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 80));
               delay  = COUNT_W'($urandom_range(0, 15));
               reload = COUNT_W'($urandom_range(0, 15));
            end
         endcase
         program_settings(center, zone, delay, reload);
         if (phase == 4) begin
            req_burst = 1'b1;
            rsp_burst = 1'b0;
            hold_rsp  = 1'b1;
         end else begin
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
         end
         random_phase(PHASE_ITEMS);
         drain();
      end

      $display("covered %0d requests and %0d responses over %0d register settings",
               board.requests, board.responses, settings_used);
      $display("%0d auto-repeat responses, %0d register writes including unknown indexes",
               board.repeats, board.writes);
      if (board.errors == 0 && board.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
